### hdl/four_level_page_walk_translate_assert.svh
`ifndef FOUR_LEVEL_PAGE_WALK_TRANSLATE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALK_TRANSLATE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PWT_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PWT_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/pwt_pkg.sv
package pwt_pkg;

  // store depth, a power of two
  localparam int TABLE_WORDS = 4096;
  localparam int IDX_W       = $clog2(TABLE_WORDS);

  localparam int PA_W      = 52;
  localparam int VA_W      = 48;
  localparam int ENTRY_W   = 64;
  localparam int EIDX_W    = 12;
  localparam int FRAME_W   = 40;
  localparam int LVL_IDX_W = 9;
  localparam int PAGE_SH   = 12;

  localparam int PRESENT_BIT = 0;
  localparam int SIZE_BIT    = 7;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  localparam logic [1:0] PSIZE_4K = 2'd0;
  localparam logic [1:0] PSIZE_2M = 2'd1;
  localparam logic [1:0] PSIZE_1G = 2'd2;

  typedef logic [2:0] step_t;
  localparam step_t STEP_ACC = 3'd0;
  localparam step_t STEP_L1  = 3'd1;
  localparam step_t STEP_L2  = 3'd2;
  localparam step_t STEP_L3  = 3'd3;
  localparam step_t STEP_L4  = 3'd4;
  localparam step_t STEP_WR  = 3'd5;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_4K   = 2'd1,
    RES_2M   = 2'd2,
    RES_1G   = 2'd3
  } res_e;

  typedef struct packed {
    logic       accept;
    logic       check;
    logic [1:0] lvl;
    logic       big_ok;
    res_e       big_res;
    logic       last;
    logic       wr_result;
    step_t      next;
    step_t      jmp;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic op_translate;
    logic out_free;
    logic present;
    logic size;
    logic clearing;
  } seq_stat_t;

  typedef struct packed {
    logic       in_ready;
    logic       wr_en;
    logic       rd_en;
    logic [1:0] rd_lvl;
    logic       use_input_va;
    logic       emit;
    res_e       res;
  } seq_ctl_t;

  // walk program: jmp is taken on a write transaction or when a walk result goes out
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w         = '0;
    w.big_res = RES_ZERO;
    w.next    = STEP_ACC;
    w.jmp     = STEP_ACC;
    case (s)
      STEP_ACC: begin
        w.accept = 1'b1;
        w.lvl    = 2'd0;
        w.next   = STEP_L1;
        w.jmp    = STEP_WR;
      end
      STEP_L1: begin
        w.check = 1'b1;
        w.lvl   = 2'd1;
        w.next  = STEP_L2;
      end
      STEP_L2: begin
        w.check   = 1'b1;
        w.lvl     = 2'd2;
        w.big_ok  = 1'b1;
        w.big_res = RES_1G;
        w.next    = STEP_L3;
      end
      STEP_L3: begin
        w.check   = 1'b1;
        w.lvl     = 2'd3;
        w.big_ok  = 1'b1;
        w.big_res = RES_2M;
        w.next    = STEP_L4;
      end
      STEP_L4: begin
        w.check = 1'b1;
        w.last  = 1'b1;
      end
      STEP_WR: begin
        w.wr_result = 1'b1;
      end
      default: begin
        w.next = STEP_ACC;
      end
    endcase
    return w;
  endfunction

  function automatic logic [LVL_IDX_W-1:0] va_index(logic [VA_W-1:0] va, logic [1:0] lvl);
    logic [LVL_IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // frame is 4 KiB aligned, so word = {frame, idx} with no carry, then wrap to the depth
  function automatic logic [IDX_W-1:0] table_addr(logic [FRAME_W-1:0] frame,
                                                  logic [LVL_IDX_W-1:0] idx);
    return IDX_W'({frame, idx});
  endfunction

endpackage

### hdl/pwt_store.sv
module pwt_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [pwt_pkg::IDX_W-1:0]           wr_addr_i,
  input  logic [pwt_pkg::ENTRY_W-1:0]         wr_data_i,
  input  logic                                rd_en_i,
  input  logic [pwt_pkg::IDX_W-1:0]           rd_addr_i,
  output logic [pwt_pkg::ENTRY_W-1:0]         rd_data_o,
  output logic                                clearing_o
);
  import pwt_pkg::*;

  logic [ENTRY_W-1:0] mem_q [TABLE_WORDS];
  logic [ENTRY_W-1:0] rd_data_q;
  logic               clr_q;
  logic [IDX_W-1:0]   clr_addr_q;

  // zero sweep after reset, one word per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read so a stalled step still sees its entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_q;

endmodule

### hdl/pwt_seq.sv
module pwt_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pwt_pkg::seq_stat_t   stat_i,
  output pwt_pkg::seq_ctl_t    ctl_o
);
  import pwt_pkg::*;

  step_t     step_q, step_d;
  uword_t    w;
  seq_ctl_t  ctl;
  logic      want_emit;
  res_e      want_res;

  always_comb begin
    w         = ucode_rom(step_q);
    ctl       = '0;
    ctl.res   = RES_ZERO;
    step_d    = step_q;
    want_emit = 1'b0;
    want_res  = RES_ZERO;

    if (w.accept) begin
      ctl.in_ready = !stat_i.clearing;
      if (stat_i.in_valid && !stat_i.clearing) begin
        if (stat_i.op_translate) begin
          ctl.rd_en        = 1'b1;
          ctl.rd_lvl       = w.lvl;
          ctl.use_input_va = 1'b1;
          step_d           = w.next;
        end else begin
          ctl.wr_en = 1'b1;
          step_d    = w.jmp;
        end
      end
    end else if (w.check) begin
      if (!stat_i.present) begin
        want_emit = 1'b1;
        want_res  = RES_ZERO;
      end else if (w.big_ok && stat_i.size) begin
        want_emit = 1'b1;
        want_res  = w.big_res;
      end else if (w.last) begin
        want_emit = 1'b1;
        want_res  = RES_4K;
      end else begin
        ctl.rd_en  = 1'b1;
        ctl.rd_lvl = w.lvl;
        step_d     = w.next;
      end
    end else if (w.wr_result) begin
      want_emit = 1'b1;
      want_res  = RES_ZERO;
    end else begin
      step_d = w.next;
    end

    // hold the step until the output register can take the result
    if (want_emit && stat_i.out_free) begin
      ctl.emit = 1'b1;
      ctl.res  = want_res;
      step_d   = w.wr_result ? w.next : w.jmp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ACC;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl_o = ctl;

endmodule

### hdl/four_level_page_walk_translate.sv
// Four-level page table walker with its own 4096 x 64-bit table store. A write transaction
// (tuser operation 0) stores one entry and returns an all-zero result; a translate transaction
// walks the tables from root_table_base and returns the physical address, mapped flag and
// page size. The store has one synchronous read port, so the levels are read one after
// another, and a walk ends early at a 2 MiB or 1 GiB page or at a level that is not present;
// the next transaction is accepted once the result is in the output register. After reset all
// 4096 words of the store are swept to zero, during which no transaction is accepted; the
// root register can be written at any time the block is idle.
`include "four_level_page_walk_translate_assert.svh"

module four_level_page_walk_translate (
  input  logic         clk_i,
  input  logic         rst_ni,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[11:0], entry_value[75:12], virtual_address[123:76], zero pad
  input  logic [127:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // physical_address[51:0], mapped[52], page_size[54:53], zero pad
  output logic [55:0]  m_axis_tdata
);
  import pwt_pkg::*;

  logic [PA_W-1:0]    root_q;
  logic [VA_W-1:0]    va_q;
  logic               out_valid_q;
  logic [55:0]        out_data_q;

  logic [EIDX_W-1:0]  in_eidx;
  logic [ENTRY_W-1:0] in_entry;
  logic [VA_W-1:0]    in_va;
  logic               in_op;

  logic [ENTRY_W-1:0] rd_data;
  logic               clearing;
  logic               out_free;
  seq_stat_t          stat;
  seq_ctl_t           ctl;

  logic [VA_W-1:0]    va_sel;
  logic [FRAME_W-1:0] frame_sel;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [PA_W-1:0]    frame_pa;
  logic [PA_W-1:0]    res_pa;
  logic               res_mapped;
  logic [1:0]         res_size;
  logic               cfg_wr;

  assign in_eidx  = s_axis_tdata[11:0];
  assign in_entry = s_axis_tdata[75:12];
  assign in_va    = s_axis_tdata[123:76];
  assign in_op    = s_axis_tuser[0];

  // register 0 occupies byte addresses 0 to 7
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[3];
  assign prdata = paddr[3] ? 64'd0 : {12'd0, root_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr) begin
      root_q <= pwdata[PA_W-1:0];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  assign stat.in_valid     = s_axis_tvalid;
  assign stat.op_translate = (in_op == OP_TRANSLATE);
  assign stat.out_free     = out_free;
  assign stat.present      = rd_data[PRESENT_BIT];
  assign stat.size         = rd_data[SIZE_BIT];
  assign stat.clearing     = clearing;

  pwt_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // level 0 is issued in the accept cycle straight from the input and the root
  assign va_sel    = ctl.use_input_va ? in_va : va_q;
  assign frame_sel = ctl.use_input_va ? root_q[PA_W-1:PAGE_SH] : rd_data[PA_W-1:PAGE_SH];
  assign rd_addr   = table_addr(frame_sel, va_index(va_sel, ctl.rd_lvl));
  assign wr_addr   = IDX_W'(in_eidx);

  pwt_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (ctl.wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (in_entry),
    .rd_en_i    (ctl.rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .clearing_o (clearing)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.use_input_va && ctl.rd_en) begin
      va_q <= in_va;
    end
  end

  assign frame_pa = {rd_data[PA_W-1:PAGE_SH], {PAGE_SH{1'b0}}};

  always_comb begin
    case (ctl.res)
      RES_4K: begin
        res_pa     = frame_pa;
        res_mapped = 1'b1;
        res_size   = PSIZE_4K;
      end
      RES_2M: begin
        res_pa     = frame_pa + {31'd0, va_q[20:0]};
        res_mapped = 1'b1;
        res_size   = PSIZE_2M;
      end
      RES_1G: begin
        res_pa     = frame_pa + {22'd0, va_q[29:0]};
        res_mapped = 1'b1;
        res_size   = PSIZE_1G;
      end
      default: begin
        res_pa     = '0;
        res_mapped = 1'b0;
        res_size   = PSIZE_4K;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_data_q <= {1'b0, res_size, res_mapped, res_pa};
    end
  end

  assign s_axis_tready = ctl.in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `PWT_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !clearing, "transaction accepted during store clear")
  `PWT_ASSERT_NOW(a_emit_needs_room, clk_i, rst_ni, ctl.emit, out_free, "result would overwrite a pending result")
  `PWT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second transaction accepted while one is in flight")
  `PWT_ASSERT_NOW(a_page_size_legal, clk_i, rst_ni, out_valid_q, out_data_q[54:53] != 2'b11, "illegal page size code on output")

endmodule

### tb/sv/tb_top.sv
module tb_top;
  import pwt_pkg::*;

  localparam logic [3:0] REG_ROOT_BASE = 4'h0;
  // no register behind this address, writes must not land anywhere
  localparam logic [3:0] REG_UNUSED    = 4'h8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_CYCLES = 300;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic            mapped;
    logic [1:0]      psize;
  } translation_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // entry_index[11:0], entry_value[75:12], virtual_address[123:76], zero pad
  logic [127:0] s_axis_tdata = '0;
  // operation[0]
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // physical_address[51:0], mapped[52], page_size[54:53], zero pad
  logic [55:0]  m_axis_tdata;

  four_level_page_walk_translate dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block's table store and root register
  logic [ENTRY_W-1:0] table_mem [TABLE_WORDS];
  logic [PA_W-1:0]    root_base = '0;
  translation_t       pending_results[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit stall_request = 1'b0;
  int stall_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int n_writes = 0;
  int n_unmapped = 0;
  int n_leaf [3] = '{0, 0, 0};
  int n_roots = 0;

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ENTRY_W-1:0] read_table(logic [63:0] base, logic [63:0] idx);
    logic [63:0] word;
    word = (64'({base[51:12], 12'b0}) >> 3) + (idx & 64'h1FF);
    return table_mem[IDX_W'(word)];
  endfunction

  function automatic translation_t walk_tables(logic [VA_W-1:0] va);
    translation_t r;
    logic [63:0]  e;
    logic [63:0]  v;
    r = '0;
    v = 64'(va);
    e = read_table(64'(root_base), v >> 39);
    if (!e[PRESENT_BIT]) return r;
    e = read_table(e, v >> 30);
    if (!e[PRESENT_BIT]) return r;
    if (e[SIZE_BIT]) begin
      r.pa     = {e[51:12], 12'b0} + v[29:0];
      r.mapped = 1'b1;
      r.psize  = PSIZE_1G;
      return r;
    end
    e = read_table(e, v >> 21);
    if (!e[PRESENT_BIT]) return r;
    if (e[SIZE_BIT]) begin
      r.pa     = {e[51:12], 12'b0} + v[20:0];
      r.mapped = 1'b1;
      r.psize  = PSIZE_2M;
      return r;
    end
    e = read_table(e, v >> 12);
    if (!e[PRESENT_BIT]) return r;
    r.pa     = {e[51:12], 12'b0};
    r.mapped = 1'b1;
    r.psize  = PSIZE_4K;
    return r;
  endfunction

  function automatic void record_item(logic op, logic [EIDX_W-1:0] idx,
                                      logic [ENTRY_W-1:0] val, logic [VA_W-1:0] va);
    translation_t r;
    r = '0;
    if (op == OP_WRITE) begin
      table_mem[IDX_W'(idx)] = val;
      n_writes++;
    end else begin
      r = walk_tables(va);
      if (r.mapped) n_leaf[r.psize]++;
      else n_unmapped++;
    end
    pending_results.push_back(r);
  endfunction

  // low frame bits pick one of the eight 512-entry tables in the store
  function automatic logic [63:0] make_entry(logic present, logic size, logic [2:0] slot);
    logic [63:0] e;
    e = random_word();
    e[PRESENT_BIT] = present;
    e[SIZE_BIT]    = size;
    e[14:12]       = slot;
    return e;
  endfunction

  task automatic send_item(logic op, logic [EIDX_W-1:0] idx, logic [ENTRY_W-1:0] val,
                           logic [VA_W-1:0] va);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, va, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    record_item(op, idx, val, va);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == REG_ROOT_BASE) begin
      root_base = data[PA_W-1:0];
      n_roots++;
    end
  endtask

  // lays down the entries for one walk, then translates through them
  task automatic build_walk();
    logic [VA_W-1:0]      va;
    logic [2:0]           slot;
    logic [2:0]           next_slot;
    logic [LVL_IDX_W-1:0] lvl_idx;
    logic                 present;
    logic                 size;
    int                   end_lvl;
    int                   fault_lvl;
    int                   n_probe;
    va        = VA_W'(random_word());
    slot      = root_base[14:12];
    end_lvl   = $urandom_range(1, 3);
    fault_lvl = ($urandom_range(4) == 0) ? int'($urandom_range(end_lvl)) : -1;
    for (int lvl = 0; lvl <= end_lvl; lvl++) begin
      lvl_idx   = LVL_IDX_W'(va >> (39 - 9 * lvl));
      next_slot = 3'($urandom_range(7));
      present   = (lvl != fault_lvl);
      // size bit means nothing at the top and last level
      if (lvl == 0 || lvl == 3) size = 1'($urandom_range(1));
      else size = (lvl == end_lvl);
      send_item(OP_WRITE, {slot, lvl_idx}, make_entry(present, size, next_slot),
                VA_W'(random_word()));
      if (!present) break;
      slot = next_slot;
    end
    n_probe = $urandom_range(1, 3);
    for (int i = 0; i < n_probe; i++) begin
      send_item(OP_TRANSLATE, EIDX_W'($urandom_range(4095)), random_word(), va);
      va[20:0] = 21'($urandom);
    end
  endtask

  task automatic test_directed();
    logic [VA_W-1:0] va;
    va = {9'd1, 9'd2, 9'd3, 9'd4, 12'hABC};
    apb_write(REG_ROOT_BASE, '0);
    // empty store, nothing present at the top
    send_item(OP_TRANSLATE, '0, '0, '0);
    send_item(OP_WRITE, {3'd0, 9'd1}, 64'h0000_0000_0000_1081, '0);
    send_item(OP_WRITE, {3'd1, 9'd2}, 64'h0000_0000_0000_2001, '0);
    send_item(OP_WRITE, {3'd2, 9'd3}, 64'h0000_0000_0000_3001, '0);
    send_item(OP_TRANSLATE, '0, '0, va);
    send_item(OP_WRITE, {3'd3, 9'd4}, 64'h0001_2345_6789_5081, '0);
    send_item(OP_TRANSLATE, '0, '0, va);
    send_item(OP_WRITE, {3'd2, 9'd3}, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(OP_TRANSLATE, '0, '0, va);
    // 2 MiB page at the top of physical space, offset carries out and wraps
    send_item(OP_WRITE, {3'd2, 9'd3}, '1, '0);
    send_item(OP_TRANSLATE, '0, '0, {va[47:21], 21'h1FFFFF});
    send_item(OP_WRITE, {3'd1, 9'd2}, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(OP_TRANSLATE, '0, '0, va);
    send_item(OP_WRITE, {3'd1, 9'd2}, '1, '0);
    send_item(OP_TRANSLATE, '0, '0, {va[47:30], 30'h3FFFFFFF});
    send_item(OP_WRITE, 12'h000, '0, '1);
    send_item(OP_WRITE, 12'hFFF, '1, '1);
    wait_idle();
    apb_write(REG_ROOT_BASE, '1);
    apb_write(REG_UNUSED, '0);
    send_item(OP_TRANSLATE, '1, '1, '1);
    send_item(OP_TRANSLATE, '1, '1, 48'h0000_7FFF_FFFF);
    wait_idle();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
    int start;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_idle();
      apb_write(REG_ROOT_BASE, random_word());
      start = items_sent;
      while (items_sent - start < n_items / 4) begin
        pick = $urandom_range(99);
        if (pick < 70) build_walk();
        else if (pick < 85)
          send_item(OP_TRANSLATE, EIDX_W'($urandom_range(4095)), random_word(),
                    VA_W'(random_word()));
        else
          send_item(OP_WRITE, EIDX_W'($urandom_range(4095)), random_word(),
                    VA_W'(random_word()));
      end
    end
  endtask

  // receiver holds off while the sender keeps pushing
  task automatic test_output_backpressure();
    int start;
    wait_idle();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    stall_request = 1'b1;
    start = items_sent;
    while (items_sent - start < 60) build_walk();
  endtask

  always @(posedge clk_i) begin
    if (stall_request) begin
      stall_left    = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    translation_t got;
    translation_t want;
    got.pa     = m_axis_tdata[51:0];
    got.mapped = m_axis_tdata[52];
    got.psize  = m_axis_tdata[54:53];
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got pa=%h mapped=%b size=%0d",
                 $time, got.pa, got.mapped, got.psize);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected pa=%h mapped=%b size=%0d, got pa=%h mapped=%b size=%0d",
                   $time, want.pa, want.mapped, want.psize,
                   got.pa, got.mapped, got.psize);
        end
      end
    end
  end

  initial begin
    foreach (table_mem[i]) table_mem[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(22, 48, 700);
    test_random_traffic(48, 22, 700);
    test_random_traffic(0, 0, 600);
    test_output_backpressure();
    wait_idle();
    mismatches += pending_results.size();
    $display("covered %0d table writes and %0d translations across %0d root settings",
             n_writes, items_sent - n_writes, n_roots);
    $display("walk outcomes: %0d 4 KiB, %0d 2 MiB, %0d 1 GiB, %0d unmapped",
             n_leaf[PSIZE_4K], n_leaf[PSIZE_2M], n_leaf[PSIZE_1G], n_unmapped);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pwt_pkg.sv
hdl/pwt_store.sv
hdl/pwt_seq.sv
hdl/four_level_page_walk_translate.sv
tb/sv/tb_top.sv
